// ===== rtl/trf_pkg.sv =====
package trf_pkg;

    localparam int unsigned DIV_BITS = 64;
    localparam int unsigned CNT_W    = $clog2(DIV_BITS);

    localparam logic [9:0]  PERMILLE   = 10'd1000;
    localparam int unsigned CONF_STEPS = 16;
    // Largest difference whose product with 1000 still fits in 64 bits.
    localparam logic [63:0] DIFF_LIMIT = 64'd18446744073709551;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_LAT_RISE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_THR_DROP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PRESSURE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_THERMAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HEALTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_QUEUE    = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic diff;
        logic mul;
        logic step;
        logic save;
        logic finish;
        logic sel_thr;
    } trf_cmd_t;

endpackage

// ===== rtl/telemetry_regression_forecast_top.sv =====
// Channel | Handshake           | Payload
// in      | in_valid/in_ready   | latency, throughput, pressure, thermal, health,
//         |                     | queue_level, miss_count
// out     | out_valid/out_ready | forecast_number, risk, confidence, flag_bits,
//         |                     | predicted_latency, predicted_throughput
// cfg     | cfg_we              | cfg_index, cfg_data
//
// A result is offered after two ratio passes (difference, scale by 1000, 64 steps
// of the shared one-bit restoring divider, save) and a load of the output
// register. A new sample is taken only after the previous result has been
// loaded, and that load waits until the output register is free.
// Reset clears the controller, the configuration and the sample history at once.
// A result waiting on out_ready does not block the next input beat; only the final
// load stalls until the output register is free.
module telemetry_regression_forecast_top
    import trf_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [63:0]           latency,
    input  logic [63:0]           throughput,
    input  logic [9:0]            pressure,
    input  logic [9:0]            thermal,
    input  logic [9:0]            health,
    input  logic [15:0]           queue_level,
    input  logic [15:0]           miss_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           forecast_number,
    output logic [9:0]            risk,
    output logic [9:0]            confidence,
    output logic [5:0]            flag_bits,
    output logic [63:0]           predicted_latency,
    output logic [63:0]           predicted_throughput,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    trf_cmd_t cmd;

    // The controller sequences both ratio passes and owns the handshakes.
    trf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // The datapath holds configuration, history, the divider and the result.
    trf_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .latency              (latency),
        .throughput           (throughput),
        .pressure             (pressure),
        .thermal              (thermal),
        .health               (health),
        .queue_level          (queue_level),
        .miss_count           (miss_count),
        .forecast_number      (forecast_number),
        .risk                 (risk),
        .confidence           (confidence),
        .flag_bits            (flag_bits),
        .predicted_latency    (predicted_latency),
        .predicted_throughput (predicted_throughput)
    );

endmodule

// ===== rtl/trf_ctrl.sv =====
module trf_ctrl
    import trf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output trf_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_DIV,
        ST_SAVE,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic               sel_reg, sel_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.sel_thr    = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    sel_next    = 1'b0;
                    state_next  = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_BITS - 1))
                begin
                    state_next = ST_SAVE;
                end
            end
            ST_SAVE:
            begin
                cmd.save = 1'b1;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = ST_DIFF;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/trf_dp.sv =====
module trf_dp
    import trf_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  trf_cmd_t              cmd,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [63:0]           latency,
    input  logic [63:0]           throughput,
    input  logic [9:0]            pressure,
    input  logic [9:0]            thermal,
    input  logic [9:0]            health,
    input  logic [15:0]           queue_level,
    input  logic [15:0]           miss_count,
    output logic [31:0]           forecast_number,
    output logic [9:0]            risk,
    output logic [9:0]            confidence,
    output logic [5:0]            flag_bits,
    output logic [63:0]           predicted_latency,
    output logic [63:0]           predicted_throughput
);

    localparam int unsigned SEEN_W = $clog2(WINDOW_DEPTH + 1);

    // Configuration.
    logic [9:0]  max_lat_rise_reg, max_thr_drop_reg, max_pressure_reg;
    logic [9:0]  max_thermal_reg, min_health_reg;
    logic [15:0] max_queue_reg;

    // Persistent state.
    logic [63:0]       prev_lat_reg, prev_thr_reg, older_lat_reg;
    logic [9:0]        prev_pres_reg, prev_therm_reg, prev_hlth_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [31:0]       counter_reg;

    // Captured sample.
    logic [63:0] lat_reg, thr_reg;
    logic [9:0]  pres_reg, therm_reg, hlth_reg;
    logic [15:0] queue_reg, miss_reg;

    // Ratio unit.
    logic [63:0] diff_reg, base_reg, quo_reg;
    logic [64:0] rem_reg;
    logic        app_reg, big_reg;
    logic [9:0]  rise_reg, drop_reg;

    // Output payload.
    logic [31:0] fnum_reg;
    logic [9:0]  risk_reg, conf_reg;
    logic [5:0]  flags_reg;
    logic [63:0] plat_reg, pthr_reg;

    logic [63:0] op_a, op_b;
    logic [64:0] rem_shift, rem_sub;
    logic [9:0]  ratio;

    always_comb
    begin
        op_a      = cmd.sel_thr ? prev_thr_reg : lat_reg;
        op_b      = cmd.sel_thr ? thr_reg : prev_lat_reg;
        rem_shift = {rem_reg[63:0], quo_reg[63]};
        rem_sub   = rem_shift - {1'b0, base_reg};
        if (!app_reg)
        begin
            ratio = '0;
        end
        else if (big_reg || quo_reg > 64'(PERMILLE))
        begin
            ratio = PERMILLE;
        end
        else
        begin
            ratio = quo_reg[9:0];
        end
    end

    // Result assembly.
    logic        hard, seen_ge1, seen_ge2, lat_up, thr_down;
    logic [9:0]  risk_base, risk_a, risk_b;
    logic [5:0]  flags;
    logic [31:0] conf_w;
    logic [9:0]  conf;
    logic [64:0] lat_sum, thr_dif;
    logic [63:0] plat, pthr;

    always_comb
    begin
        hard = (miss_reg != '0) || (hlth_reg < min_health_reg)
            || (pres_reg > max_pressure_reg) || (therm_reg > max_thermal_reg)
            || (queue_reg > max_queue_reg);
        seen_ge1 = (seen_reg != '0);
        seen_ge2 = (32'(seen_reg) >= 32'd2);
        lat_up   = lat_reg > prev_lat_reg;
        thr_down = thr_reg < prev_thr_reg;
        if (32'(seen_reg) >= CONF_STEPS)
        begin
            conf_w = 32'(PERMILLE);
        end
        else
        begin
            conf_w = (32'(seen_reg) * 32'd125) >> 1;
        end
        conf = conf_w[9:0];

        flags = '0;
        if (hard)
        begin
            risk_base = PERMILLE;
        end
        else
        begin
            risk_base = (pres_reg > therm_reg) ? pres_reg : therm_reg;
            flags[0]  = queue_reg > {1'b0, max_queue_reg[15:1]};
        end
        risk_a = risk_base;
        lat_sum = {1'b0, lat_reg} + {1'b0, lat_reg - prev_lat_reg};
        thr_dif = {1'b0, thr_reg} - {1'b0, prev_thr_reg - thr_reg};
        plat = lat_reg;
        pthr = thr_reg;
        if (seen_ge1)
        begin
            flags[1] = rise_reg > max_lat_rise_reg;
            flags[2] = drop_reg > max_thr_drop_reg;
            if (rise_reg > risk_a)
            begin
                risk_a = rise_reg;
            end
            flags[3] = pres_reg > prev_pres_reg;
            flags[4] = therm_reg > prev_therm_reg;
            flags[5] = hlth_reg < prev_hlth_reg;
            if (lat_up)
            begin
                plat = lat_sum[64] ? '1 : lat_sum[63:0];
            end
            if (thr_down)
            begin
                pthr = thr_dif[64] ? '0 : thr_dif[63:0];
            end
        end
        risk_b = risk_a;
        if (seen_ge1 && drop_reg > risk_b)
        begin
            risk_b = drop_reg;
        end
        if (seen_ge2 && lat_up && prev_lat_reg > older_lat_reg)
        begin
            flags[1] = 1'b1;
        end
        if (risk_b > PERMILLE)
        begin
            risk_b = PERMILLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lat_rise_reg <= PERMILLE;
            max_thr_drop_reg <= PERMILLE;
            max_pressure_reg <= PERMILLE;
            max_thermal_reg  <= PERMILLE;
            min_health_reg   <= '0;
            max_queue_reg    <= 16'hFFFF;
            prev_lat_reg     <= '0;
            prev_thr_reg     <= '0;
            older_lat_reg    <= '0;
            prev_pres_reg    <= '0;
            prev_therm_reg   <= '0;
            prev_hlth_reg    <= '0;
            seen_reg         <= '0;
            counter_reg      <= 32'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_LAT_RISE: max_lat_rise_reg <= cfg_data[9:0];
                    REG_MAX_THR_DROP: max_thr_drop_reg <= cfg_data[9:0];
                    REG_MAX_PRESSURE: max_pressure_reg <= cfg_data[9:0];
                    REG_MAX_THERMAL:  max_thermal_reg  <= cfg_data[9:0];
                    REG_MIN_HEALTH:   min_health_reg   <= cfg_data[9:0];
                    REG_MAX_QUEUE:    max_queue_reg    <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.finish)
            begin
                older_lat_reg  <= prev_lat_reg;
                prev_lat_reg   <= lat_reg;
                prev_thr_reg   <= thr_reg;
                prev_pres_reg  <= pres_reg;
                prev_therm_reg <= therm_reg;
                prev_hlth_reg  <= hlth_reg;
                if (32'(seen_reg) < WINDOW_DEPTH)
                begin
                    seen_reg <= seen_reg + 1'b1;
                end
                counter_reg <= counter_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lat_reg   <= latency;
            thr_reg   <= throughput;
            pres_reg  <= pressure;
            therm_reg <= thermal;
            hlth_reg  <= health;
            queue_reg <= queue_level;
            miss_reg  <= miss_count;
        end
        if (cmd.diff)
        begin
            diff_reg <= op_a - op_b;
            base_reg <= cmd.sel_thr ? prev_thr_reg : prev_lat_reg;
            app_reg  <= (op_a > op_b)
                && ((cmd.sel_thr ? prev_thr_reg : prev_lat_reg) != '0);
        end
        if (cmd.mul)
        begin
            // Times 1000 as 1024 - 16 - 8.
            quo_reg <= (diff_reg << 10) - (diff_reg << 4) - (diff_reg << 3);
            rem_reg <= '0;
            big_reg <= diff_reg > DIFF_LIMIT;
        end
        if (cmd.step)
        begin
            if (!rem_sub[64])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (cmd.save)
        begin
            if (cmd.sel_thr)
            begin
                drop_reg <= ratio;
            end
            else
            begin
                rise_reg <= ratio;
            end
        end
        if (cmd.finish)
        begin
            fnum_reg  <= counter_reg;
            risk_reg  <= risk_b;
            conf_reg  <= conf;
            flags_reg <= flags;
            plat_reg  <= plat;
            pthr_reg  <= pthr;
        end
    end

    assign forecast_number      = fnum_reg;
    assign risk                 = risk_reg;
    assign confidence           = conf_reg;
    assign flag_bits            = flags_reg;
    assign predicted_latency    = plat_reg;
    assign predicted_throughput = pthr_reg;

endmodule

// ===== rtl/trf_chk.sv =====
module trf_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] forecast_number,
    input logic [9:0]  risk,
    input logic [9:0]  confidence
);

    // A held result must not change while stalled.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(forecast_number) && $stable(risk))
        else $error("result changed while stalled");

    // An accepted sample keeps the input side closed on the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input reopened right after a beat");

    // No result can appear the cycle after a sample is taken.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result produced too early");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> risk <= 10'd1000 && confidence <= 10'd1000)
        else $error("permille value out of range");

endmodule

bind telemetry_regression_forecast_top trf_chk u_trf_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .forecast_number (forecast_number),
    .risk            (risk),
    .confidence      (confidence)
);
